>>> rtl/vtl_pkg.sv
// Shared types and constants for the reply-text tuple lexer.
// Used by the lexer top level and by its port checker; depends on nothing.
`timescale 1ns / 1ps

package vtl_pkg;

  // Result kinds, carried on the output tuser.
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_STREND  = 2'd1;
  localparam logic [1:0] KIND_NUMBER  = 2'd2;
  localparam logic [1:0] KIND_VERDICT = 2'd3;

  // Scanner modes.
  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_STRING = 3'd1;
  localparam logic [2:0] MODE_ESCAPE = 3'd2;
  localparam logic [2:0] MODE_MINUS  = 3'd3;
  localparam logic [2:0] MODE_NUMBER = 3'd4;
  localparam logic [2:0] MODE_IDENT  = 3'd5;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 4;
  localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_STRINGS = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_NUMBERS = 4'd1;

  // Characters the scanner looks for.
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [63:0] MAG_CAP = 64'h8000_0000_0000_0000;
  localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned OUT_DATA_W  = 80;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_out;
    logic [63:0] num_value;
    logic [3:0]  token_index;
    logic        ok;
    logic        last;
  } res_t;

endpackage

>>> rtl/variant_text_tuple_lexer_top.sv
// Reply-text tuple lexer: byte stream in, string bytes, numbers and a verdict out.
// Depends on vtl_pkg for result kinds, scanner modes and the result type.
`timescale 1ns / 1ps

// One text byte is taken per beat. The byte and the scanner state go through
// one pass of logic into a three-entry result register. While m_tready is
// high, the register drains one result beat per cycle and a byte that causes
// zero or one result admits the next byte in the next cycle, so the block runs
// at one byte per cycle; one with more (up to three, at end of text) holds the
// input until the last is taken. Strings go out byte by byte with a string-end
// beat, numbers as one saturated 64-bit beat, and every reply closes with a
// verdict beat marked by tlast. The user must write the two expected counts
// through the cfg channel while the block is idle; it is not enforced.
module variant_text_tuple_lexer_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,   // [7:0] char_value
  input  logic                                s_tlast,   // end_of_text
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [7:0] byte_out, [71:8] num_value, [75:72] token_index, [76] ok, rest zero
  output logic [vtl_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic [1:0]                          m_tuser,   // [1:0] kind
  output logic                                m_tlast,   // last
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vtl_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [3:0]                          cfg_data
);

  logic [3:0]  expected_strings;
  logic [3:0]  expected_numbers;

  logic [2:0]  scan_mode, scan_mode_next;
  logic        quote_is_double, quote_is_double_next;
  logic [63:0] magnitude, magnitude_next;
  logic        is_negative, is_negative_next;
  logic [3:0]  strings_seen, strings_seen_next;
  logic [3:0]  numbers_seen, numbers_seen_next;

  vtl_pkg::res_t slot [vtl_pkg::MAX_RESULTS];
  logic [1:0]    count;

  vtl_pkg::res_t res [vtl_pkg::MAX_RESULTS];
  logic [1:0]    nres;

  logic          in_fire, out_fire;
  logic [7:0]    c;
  logic          is_dig, is_alp, fresh, do_finish, verdict_ok;
  logic [67:0]   acc;
  logic [63:0]   number_val;

  assign cfg_ready = 1'b1;
  assign s_tready  = (count == 2'd0) || (count == 2'd1 && m_tready);
  assign in_fire   = s_tvalid && s_tready;
  assign m_tvalid  = (count != 2'd0);
  assign out_fire  = m_tvalid && m_tready;

  assign m_tdata = {3'b000, slot[0].ok, slot[0].token_index, slot[0].num_value,
                    slot[0].byte_out};
  assign m_tuser = slot[0].kind;
  assign m_tlast = slot[0].last;

  assign c      = s_tdata;
  assign is_dig = (c >= 8'h30) && (c <= 8'h39);
  assign is_alp = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));

  function automatic logic [3:0] sat_inc(input logic [3:0] v);
    sat_inc = (v == 4'hF) ? 4'hF : v + 4'd1;
  endfunction

  function automatic vtl_pkg::res_t mk(input logic [1:0] kind, input logic [7:0] b,
                                       input logic [63:0] num, input logic [3:0] idx,
                                       input logic ok, input logic last);
    vtl_pkg::res_t r;
    r.kind        = kind;
    r.byte_out    = b;
    r.num_value   = num;
    r.token_index = idx;
    r.ok          = ok;
    r.last        = last;
    mk = r;
  endfunction

  always_comb begin
    scan_mode_next       = scan_mode;
    quote_is_double_next = quote_is_double;
    magnitude_next       = magnitude;
    is_negative_next     = is_negative;
    strings_seen_next    = strings_seen;
    numbers_seen_next    = numbers_seen;
    for (int i = 0; i < vtl_pkg::MAX_RESULTS; i++) begin
      res[i] = mk(vtl_pkg::KIND_BYTE, 8'd0, 64'd0, 4'd0, 1'b0, 1'b0);
    end
    nres       = 2'd0;
    fresh      = 1'b0;
    do_finish  = 1'b0;
    verdict_ok = 1'b0;
    // 10*m + d fits in 68 bits since the magnitude never exceeds 2^63.
    acc        = {1'b0, magnitude, 3'b000} + {3'b000, magnitude, 1'b0} +
                 {60'd0, c - 8'h30};
    number_val = 64'd0;

    if (c == vtl_pkg::CH_NUL) begin
      do_finish = 1'b1;
    end else begin
      do_finish = s_tlast;
      case (scan_mode)
        vtl_pkg::MODE_STRING: begin
          if (c == (quote_is_double ? vtl_pkg::CH_DQUOTE : vtl_pkg::CH_SQUOTE)) begin
            res[nres] = mk(vtl_pkg::KIND_STREND, 8'd0, 64'd0, strings_seen_next,
                           1'b0, 1'b0);
            nres = nres + 2'd1;
            strings_seen_next = sat_inc(strings_seen_next);
            scan_mode_next = vtl_pkg::MODE_IDLE;
          end else if (c == vtl_pkg::CH_BSLASH) begin
            scan_mode_next = vtl_pkg::MODE_ESCAPE;
          end else begin
            res[nres] = mk(vtl_pkg::KIND_BYTE, c, 64'd0, strings_seen_next, 1'b0, 1'b0);
            nres = nres + 2'd1;
          end
        end
        vtl_pkg::MODE_ESCAPE: begin
          res[nres] = mk(vtl_pkg::KIND_BYTE, c, 64'd0, strings_seen_next, 1'b0, 1'b0);
          nres = nres + 2'd1;
          scan_mode_next = vtl_pkg::MODE_STRING;
        end
        vtl_pkg::MODE_MINUS: begin
          if (is_dig) begin
            scan_mode_next   = vtl_pkg::MODE_NUMBER;
            is_negative_next = 1'b1;
            magnitude_next   = {56'd0, c - 8'h30};
          end else begin
            fresh = 1'b1;
          end
        end
        vtl_pkg::MODE_NUMBER: begin
          if (is_dig) begin
            magnitude_next = (acc > {4'd0, vtl_pkg::MAG_CAP}) ? vtl_pkg::MAG_CAP
                                                              : acc[63:0];
          end else begin
            number_val = is_negative ? (64'd0 - magnitude)
                       : ((magnitude > vtl_pkg::POS_MAX) ? vtl_pkg::POS_MAX : magnitude);
            res[nres] = mk(vtl_pkg::KIND_NUMBER, 8'd0, number_val, numbers_seen_next,
                           1'b0, 1'b0);
            nres = nres + 2'd1;
            numbers_seen_next = sat_inc(numbers_seen_next);
            scan_mode_next   = vtl_pkg::MODE_IDLE;
            magnitude_next   = 64'd0;
            is_negative_next = 1'b0;
            fresh = 1'b1;
          end
        end
        vtl_pkg::MODE_IDENT: begin
          fresh = !(is_alp || is_dig || c == vtl_pkg::CH_UNDER);
        end
        default: fresh = 1'b1;
      endcase

      if (fresh) begin
        if (c == vtl_pkg::CH_SQUOTE || c == vtl_pkg::CH_DQUOTE) begin
          scan_mode_next       = vtl_pkg::MODE_STRING;
          quote_is_double_next = (c == vtl_pkg::CH_DQUOTE);
        end else if (is_dig) begin
          scan_mode_next   = vtl_pkg::MODE_NUMBER;
          is_negative_next = 1'b0;
          magnitude_next   = {56'd0, c - 8'h30};
        end else if (c == vtl_pkg::CH_MINUS) begin
          scan_mode_next = vtl_pkg::MODE_MINUS;
        end else if (is_alp || c == vtl_pkg::CH_UNDER) begin
          scan_mode_next = vtl_pkg::MODE_IDENT;
        end else begin
          scan_mode_next = vtl_pkg::MODE_IDLE;
        end
      end
    end

    if (do_finish) begin
      // A string left open is closed here; a pending backslash becomes content.
      if (scan_mode_next == vtl_pkg::MODE_ESCAPE) begin
        res[nres] = mk(vtl_pkg::KIND_BYTE, vtl_pkg::CH_BSLASH, 64'd0, strings_seen_next,
                       1'b0, 1'b0);
        nres = nres + 2'd1;
      end
      if (scan_mode_next == vtl_pkg::MODE_STRING ||
          scan_mode_next == vtl_pkg::MODE_ESCAPE) begin
        res[nres] = mk(vtl_pkg::KIND_STREND, 8'd0, 64'd0, strings_seen_next, 1'b0, 1'b0);
        nres = nres + 2'd1;
        strings_seen_next = sat_inc(strings_seen_next);
      end else if (scan_mode_next == vtl_pkg::MODE_NUMBER) begin
        number_val = is_negative_next ? (64'd0 - magnitude_next)
                   : ((magnitude_next > vtl_pkg::POS_MAX) ? vtl_pkg::POS_MAX
                                                          : magnitude_next);
        res[nres] = mk(vtl_pkg::KIND_NUMBER, 8'd0, number_val, numbers_seen_next,
                       1'b0, 1'b0);
        nres = nres + 2'd1;
        numbers_seen_next = sat_inc(numbers_seen_next);
      end
      verdict_ok = (strings_seen_next == expected_strings) &&
                   (numbers_seen_next == expected_numbers);
      res[nres] = mk(vtl_pkg::KIND_VERDICT, 8'd0, 64'd0, 4'd0, verdict_ok, 1'b1);
      nres = nres + 2'd1;
      scan_mode_next       = vtl_pkg::MODE_IDLE;
      quote_is_double_next = 1'b0;
      magnitude_next       = 64'd0;
      is_negative_next     = 1'b0;
      strings_seen_next    = 4'd0;
      numbers_seen_next    = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_strings <= 4'd2;
      expected_numbers <= 4'd3;
      scan_mode        <= vtl_pkg::MODE_IDLE;
      quote_is_double  <= 1'b0;
      magnitude        <= 64'd0;
      is_negative      <= 1'b0;
      strings_seen     <= 4'd0;
      numbers_seen     <= 4'd0;
      count            <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == vtl_pkg::REG_EXPECTED_STRINGS) begin
          expected_strings <= cfg_data;
        end else if (cfg_index == vtl_pkg::REG_EXPECTED_NUMBERS) begin
          expected_numbers <= cfg_data;
        end
      end
      if (in_fire) begin
        scan_mode       <= scan_mode_next;
        quote_is_double <= quote_is_double_next;
        magnitude       <= magnitude_next;
        is_negative     <= is_negative_next;
        strings_seen    <= strings_seen_next;
        numbers_seen    <= numbers_seen_next;
        count           <= nres;
      end else if (out_fire) begin
        count <= count - 2'd1;
      end
    end
  end

  // Result register: loaded whole by an accepted byte, else shifted on each beat.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < vtl_pkg::MAX_RESULTS; i++) begin
        slot[i] <= res[i];
      end
    end else if (out_fire) begin
      for (int i = 0; i < vtl_pkg::MAX_RESULTS - 1; i++) begin
        slot[i] <= slot[i+1];
      end
    end
  end

endmodule

>>> rtl/vtl_checker.sv
// Port-level checker for the reply-text tuple lexer, bound to its top level.
// Depends on vtl_pkg for the result kinds.
`timescale 1ns / 1ps

module vtl_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [vtl_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [1:0]                     m_tuser,
  input logic                           m_tlast
);

  // A result beat that waits keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("stalled result beat changed");

  // Only the verdict closes a reply.
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == vtl_pkg::KIND_VERDICT)))
    else $error("tlast does not match the verdict kind");

  // The number field is zero on every beat that is not a number.
  a_num_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != vtl_pkg::KIND_NUMBER |-> m_tdata[71:8] == 64'd0)
    else $error("number field set on a non-number beat");

  // Content byte is zero except on string bytes, and a verdict has token index zero.
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != vtl_pkg::KIND_BYTE
      |-> m_tdata[7:0] == 8'd0 && (m_tuser != vtl_pkg::KIND_VERDICT || m_tdata[75:72] == 4'd0))
    else $error("byte or index field set where it must be zero");

  // Reset empties the result register.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat offered right after reset");

endmodule

bind variant_text_tuple_lexer_top vtl_checker u_vtl_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

>>> test/tb_lexer_checker.sv
// Port checker for the reply-text tuple lexer: mirrors the scanner on every input
// beat, queues the predicted tokens and compares each output beat against them.
// Depends on vtl_pkg for result kinds, scanner modes, characters and res_t.
`timescale 1ns / 1ps

module tb_lexer_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [7:0]                       s_tdata,
  input  logic                             s_tlast,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [vtl_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic [1:0]                       m_tuser,
  input  logic                             m_tlast,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [vtl_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [3:0]                       cfg_data,
  output int                               fail_count,
  output int                               pending
);

  import vtl_pkg::*;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  res_t        pending_tokens[$];
  logic [2:0]  mode;
  logic        quote_dbl;
  logic        neg;
  logic [63:0] mag;
  logic [3:0]  str_cnt;
  logic [3:0]  num_cnt;
  logic [3:0]  want_str;
  logic [3:0]  want_num;
  int          step_cnt;
  int          errs = 0;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [63:0] digit_of(input logic [7:0] c);
    return {56'd0, c - CH_ZERO};
  endfunction

  function automatic logic [3:0] bump(input logic [3:0] v);
    return (v == 4'd15) ? v : v + 4'd1;
  endfunction

  task automatic emit(input logic [1:0] kind, input logic [7:0] b, input logic [63:0] num,
                      input logic [3:0] idx, input logic ok, input logic last);
    res_t r;
    if (step_cnt >= MAX_RESULTS) return;
    r.kind        = kind;
    r.byte_out    = b;
    r.num_value   = num;
    r.token_index = idx;
    r.ok          = ok;
    r.last        = last;
    pending_tokens.push_back(r);
    step_cnt++;
  endtask

  task automatic clear_scan();
    mode      = MODE_IDLE;
    quote_dbl = 1'b0;
    mag       = 64'd0;
    neg       = 1'b0;
    str_cnt   = 4'd0;
    num_cnt   = 4'd0;
  endtask

  task automatic close_string();
    emit(KIND_STREND, 8'd0, 64'd0, str_cnt, 1'b0, 1'b0);
    str_cnt = bump(str_cnt);
    mode    = MODE_IDLE;
  endtask

  task automatic close_number();
    logic [63:0] v;
    if (neg) v = 64'd0 - mag;
    else v = (mag > POS_MAX) ? POS_MAX : mag;
    emit(KIND_NUMBER, 8'd0, v, num_cnt, 1'b0, 1'b0);
    num_cnt = bump(num_cnt);
    mode    = MODE_IDLE;
    mag     = 64'd0;
    neg     = 1'b0;
  endtask

  // The magnitude sticks at 2^63 once another digit would pass it.
  task automatic accumulate(input logic [7:0] c);
    logic [63:0] d;
    d = digit_of(c);
    if (mag > (MAG_CAP - d) / 64'd10) mag = MAG_CAP;
    else mag = mag * 64'd10 + d;
  endtask

  task automatic start_token(input logic [7:0] c);
    if (c == CH_SQUOTE || c == CH_DQUOTE) begin
      mode      = MODE_STRING;
      quote_dbl = (c == CH_DQUOTE);
    end else if (is_digit(c)) begin
      mode = MODE_NUMBER;
      neg  = 1'b0;
      mag  = digit_of(c);
    end else if (c == CH_MINUS) begin
      mode = MODE_MINUS;
    end else if (is_alpha(c) || c == CH_UNDER) begin
      mode = MODE_IDENT;
    end else begin
      mode = MODE_IDLE;
    end
  endtask

  task automatic lex_char(input logic [7:0] c);
    logic fresh;
    fresh = 1'b0;
    case (mode)
      MODE_STRING: begin
        if (c == (quote_dbl ? CH_DQUOTE : CH_SQUOTE)) close_string();
        else if (c == CH_BSLASH) mode = MODE_ESCAPE;
        else emit(KIND_BYTE, c, 64'd0, str_cnt, 1'b0, 1'b0);
      end
      MODE_ESCAPE: begin
        emit(KIND_BYTE, c, 64'd0, str_cnt, 1'b0, 1'b0);
        mode = MODE_STRING;
      end
      MODE_MINUS: begin
        if (is_digit(c)) begin
          mode = MODE_NUMBER;
          neg  = 1'b1;
          mag  = digit_of(c);
        end else begin
          fresh = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(c)) begin
          accumulate(c);
        end else begin
          close_number();
          fresh = 1'b1;
        end
      end
      MODE_IDENT: fresh = !(is_alpha(c) || is_digit(c) || c == CH_UNDER);
      default: fresh = 1'b1;
    endcase
    // The byte that ends a run is lexed again from scratch.
    if (fresh) start_token(c);
  endtask

  task automatic close_reply();
    logic ok;
    if (mode == MODE_STRING) begin
      close_string();
    end else if (mode == MODE_ESCAPE) begin
      emit(KIND_BYTE, CH_BSLASH, 64'd0, str_cnt, 1'b0, 1'b0);
      close_string();
    end else if (mode == MODE_NUMBER) begin
      close_number();
    end
    ok = (str_cnt == want_str) && (num_cnt == want_num);
    emit(KIND_VERDICT, 8'd0, 64'd0, 4'd0, ok, 1'b1);
    clear_scan();
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errs++;
    end
  endtask

  task automatic check_beat();
    res_t want;
    if (pending_tokens.size() == 0) begin
      $error("output beat with no token predicted: kind %0d data %h", m_tuser, m_tdata);
      errs++;
      return;
    end
    want = pending_tokens.pop_front();
    check_field("kind", 64'(want.kind), 64'(m_tuser));
    check_field("byte_out", 64'(want.byte_out), 64'(m_tdata[7:0]));
    check_field("num_value", want.num_value, m_tdata[71:8]);
    check_field("token_index", 64'(want.token_index), 64'(m_tdata[75:72]));
    check_field("ok", 64'(want.ok), 64'(m_tdata[76]));
    check_field("tdata padding", 64'd0, 64'(m_tdata[OUT_DATA_W-1:77]));
    check_field("last", 64'(want.last), 64'(m_tlast));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_scan();
      want_str = 4'd2;
      want_num = 4'd3;
      pending_tokens.delete();
    end else begin
      // Output first: nothing accepted at this edge can stem from this edge's input.
      if (m_tvalid && m_tready) check_beat();
      if (s_tvalid && s_tready) begin
        step_cnt = 0;
        if (s_tdata == CH_NUL) begin
          close_reply();
        end else begin
          lex_char(s_tdata);
          if (s_tlast) close_reply();
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_EXPECTED_STRINGS: want_str = cfg_data;
          REG_EXPECTED_NUMBERS: want_num = cfg_data;
          default: ;
        endcase
      end
    end
    pending    <= pending_tokens.size();
    fail_count <= errs;
  end

endmodule

>>> test/tb_top.sv
// Testbench top for the reply-text tuple lexer: drives text replies, stalls and
// configuration writes, and reports the verdict. Depends on vtl_pkg, the lexer
// top level and tb_lexer_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module tb_top;

  import vtl_pkg::*;

  // An index past the last register; writes to it must change nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 4'd9;
  localparam int PHASE_BYTES = 56;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [7:0]              s_tdata = 8'd0;
  logic                    s_tlast = 1'b0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   m_tdata;
  logic [1:0]              m_tuser;
  logic                    m_tlast;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [3:0]              cfg_data = 4'd0;
  int                      fail_count;
  int                      pending;

  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         recv_hold = 0;
  int         items_sent = 0;
  int         cur_str = 2;
  int         cur_num = 3;
  logic [7:0] reply_text[$];

  variant_text_tuple_lexer_top dut (.*);

  tb_lexer_checker u_check (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: a requested hold-off is counted down here, otherwise random stalls.
  always @(posedge clk) begin
    if (recv_hold > 0) begin
      m_tready <= 1'b0;
      recv_hold--;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

  task automatic send_beat(input logic [7:0] c, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= eot;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // Closes the reply with tlast on its last byte, with a zero byte, or both.
  task automatic send_reply();
    int   how;
    logic eot_on_last;
    how = $urandom_range(9);
    if (how >= 6 || reply_text.size() == 0) reply_text.push_back(CH_NUL);
    eot_on_last = (how < 6 || how == 9);
    for (int i = 0; i < reply_text.size(); i++)
      send_beat(reply_text[i], eot_on_last && (i == reply_text.size() - 1));
    reply_text.delete();
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Leaves cfg_valid high so that writes can follow back to back.
  task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [3:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_counts(input int ns, input int nn);
    write_cfg(REG_EXPECTED_STRINGS, ns[3:0]);
    write_cfg(REG_UNUSED, 4'($urandom_range(15)));
    write_cfg(REG_EXPECTED_NUMBERS, nn[3:0]);
    cfg_valid <= 1'b0;
    cur_str = ns;
    cur_num = nn;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) reply_text.push_back(s[i]);
  endtask

  task automatic gen_string();
    logic [7:0] q;
    logic [7:0] c;
    int         n;
    q = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
    reply_text.push_back(q);
    n = $urandom_range(6);
    repeat (n) begin
      case ($urandom_range(5))
        0: begin
          reply_text.push_back(CH_BSLASH);
          reply_text.push_back(8'($urandom_range(1, 255)));
        end
        1: reply_text.push_back(q == CH_DQUOTE ? CH_SQUOTE : CH_DQUOTE);
        2: begin
          c = 8'($urandom_range(1, 255));
          reply_text.push_back((c == q || c == CH_BSLASH) ? 8'h78 : c);
        end
        default: begin
          c = 8'($urandom_range(32, 126));
          reply_text.push_back((c == q || c == CH_BSLASH) ? 8'h79 : c);
        end
      endcase
    end
    reply_text.push_back(q);
  endtask

  task automatic gen_number();
    logic [63:0] v;
    int          pick;
    if ($urandom_range(9) < 4) reply_text.push_back(CH_MINUS);
    if ($urandom_range(9) == 0) push_text("00");
    pick = $urandom_range(99);
    v = {$urandom, $urandom} >> $urandom_range(63);
    if (pick < 60) push_text($sformatf("%0d", $urandom_range(999)));
    else if (pick < 80) push_text($sformatf("%0d", v));
    else if (pick < 86) push_text("9223372036854775807");
    else if (pick < 92) push_text("9223372036854775808");
    else if (pick < 96) push_text("9223372036854775809");
    else push_text("99999999999999999999999");
  endtask

  task automatic gen_ident();
    case ($urandom_range(4))
      0: push_text("int");
      1: push_text("str");
      2: push_text("_");
      3: push_text("uint64_t");
      default: push_text("Tuple9x_");
    endcase
  endtask

  task automatic push_sep();
    case ($urandom_range(5))
      0: push_text(", ");
      1: push_text(",");
      2: push_text(" ");
      3: push_text(",\n");
      4: push_text(" - ");
      default: push_text(" -");
    endcase
  endtask

  // A tuple with the given numbers of strings and numbers, up to two type names in
  // between, and now and then cut short.
  task automatic gen_reply(input int ns, input int nn);
    int ni;
    int r;
    bit first;
    ni = $urandom_range(2);
    first = 1'b1;
    push_text("(");
    while (ns + nn + ni > 0) begin
      if (!first) push_sep();
      first = 1'b0;
      r = $urandom_range(ns + nn + ni - 1);
      if (r < ns) begin
        gen_string();
        ns--;
      end else if (r < ns + nn) begin
        gen_number();
        nn--;
      end else begin
        gen_ident();
        ni--;
      end
    end
    push_text(")");
    if ($urandom_range(9) == 0)
      repeat ($urandom_range(reply_text.size() - 1)) void'(reply_text.pop_back());
  endtask

  task automatic gen_noise();
    string hot;
    int    n;
    hot = "'\"\\-_09aZ";
    n = $urandom_range(1, 12);
    repeat (n) begin
      if ($urandom_range(1)) reply_text.push_back(8'($urandom_range(255)));
      else reply_text.push_back(hot[$urandom_range(hot.len() - 1)]);
    end
  endtask

  task automatic run_phase();
    int start;
    start = items_sent;
    while (items_sent - start < PHASE_BYTES) begin
      if ($urandom_range(4) == 0) gen_noise();
      else if ($urandom_range(1) == 0 && cur_str + cur_num <= 8) gen_reply(cur_str, cur_num);
      else gen_reply($urandom_range(3), $urandom_range(3));
      send_reply();
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Other quote inside a string, then a trailing backslash in an open string.
    push_text("'\"\\");
    send_reply();
    // Number then identifier, lone minus, negative number, escaped quote.
    push_text("12ab--7\"\\\"\"");
    send_reply();
    // Top byte values inside and outside a string, a number with a leading zero.
    reply_text.push_back(8'hFF);
    push_text("'");
    reply_text.push_back(8'hFF);
    push_text("'09");
    send_reply();
    // Empty reply.
    send_reply();
    drain();

    set_counts(0, 0);
    recv_hold = 400;
    run_phase();

    // Sixteen strings and seventeen numbers: the counts are held at 15, so this
    // reply should still pass.
    set_counts(15, 15);
    send_idle_pct = 84;
    push_text("(");
    repeat (16) push_text("'s',");
    repeat (17) push_text("7,");
    push_text(")");
    send_reply();
    run_phase();

    set_counts($urandom_range(5), $urandom_range(5));
    send_idle_pct = 0;
    recv_stall_pct = 84;
    run_phase();

    set_counts($urandom_range(4), $urandom_range(4));
    send_idle_pct = 37;
    recv_stall_pct = 37;
    run_phase();

    repeat (12) @(posedge clk);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
